/* rtl/kpe_pkg.sv */
package kpe_pkg;

  // payload types
  typedef logic [3:0]        key_t;
  typedef logic [31:0]       word_t;
  typedef logic signed [4:0] pos_t;
  typedef logic [3:0]        count_t;
  typedef logic [3:0]        frac_t;

  // key codes
  localparam key_t KEY_DIGIT_MAX = 4'd9;
  localparam key_t KEY_ZERO      = 4'd0;
  localparam key_t KEY_POINT     = 4'd10;
  localparam key_t KEY_BACK      = 4'd11;

  // configuration register indexes
  localparam logic CFG_FRAC = 1'b0;
  localparam logic CFG_MAX  = 1'b1;

  // status codes
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_AT_MAX = 1'b1;

  localparam pos_t   POS_NONE  = -5'sd1;
  localparam count_t COUNT_MAX = 4'd15;

  // n / 10 == (n * RECIP10) >> RECIP_SHIFT for every 32-bit n
  localparam word_t RECIP10     = 32'hCCCC_CCCD;
  localparam int    RECIP_SHIFT = 35;

  // controller to datapath
  typedef struct packed {
    logic latch;       // take the input beat, clear entry on start
    logic eval;        // decode the key, apply point and start work
    logic div_fin;     // backspace: drop the last digit
    logic mul_step;    // one clamped multiply by ten
    logic check;       // compare against max, commit or refuse digit
    logic scale_load;  // prepare scaling of the entry for output
    logic out_load;    // load the result register
  } kpe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic digit_ok;    // digit may be appended, needs max check
    logic div_need;    // backspace removes a digit
    logic cnt_zero;    // scale counter exhausted
  } kpe_stat_t;

endpackage

/* rtl/kpe_in_if.sv */
interface kpe_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  kpe_pkg::key_t    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

/* rtl/kpe_out_if.sv */
interface kpe_out_if;
  logic             valid;
  logic             ready;
  logic             status;
  kpe_pkg::word_t   digits_value;
  kpe_pkg::pos_t    point_position;
  kpe_pkg::count_t  digit_count;
  kpe_pkg::word_t   scaled_value;

  modport source (output valid, output status, output digits_value,
                  output point_position, output digit_count,
                  output scaled_value, input ready);
  modport sink   (input valid, input status, input digits_value,
                  input point_position, input digit_count,
                  input scaled_value, output ready);
endinterface

/* rtl/kpe_ctrl.sv */
module kpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  kpe_pkg::kpe_stat_t stat,
  output kpe_pkg::kpe_cmd_t  cmd
);
  import kpe_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_LOAD  = 8'b0010_0000,
    S_SCALE = 8'b0100_0000,
    S_PUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.digit_ok)      state_nxt = S_MUL;
        else if (stat.div_need) state_nxt = S_DIV;
        else                    state_nxt = S_LOAD;
      end
      S_DIV: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_MUL: begin
        if (stat.cnt_zero) state_nxt = S_CHECK;
        else               cmd.mul_step = 1'b1;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.scale_load = 1'b1;
        state_nxt      = S_SCALE;
      end
      S_SCALE: begin
        if (stat.cnt_zero) state_nxt = S_PUT;
        else               cmd.mul_step = 1'b1;
      end
      S_PUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/kpe_dp.sv */
module kpe_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  kpe_pkg::word_t     cfg_wdata,
  input  logic               in_action,
  input  kpe_pkg::key_t      in_key,
  input  kpe_pkg::kpe_cmd_t  cmd,
  output kpe_pkg::kpe_stat_t stat,
  output logic               out_status,
  output kpe_pkg::word_t     out_digits_value,
  output kpe_pkg::pos_t      out_point_position,
  output kpe_pkg::count_t    out_digit_count,
  output kpe_pkg::word_t     out_scaled_value
);
  import kpe_pkg::*;

  localparam logic [32:0] LIM33 = 33'h1_0000_0000;

  // exponent of the scaling: fraction setting less typed fraction digits, floor 0
  function automatic count_t scale_cnt(input frac_t fd, input pos_t pos);
    logic [3:0] p;
    logic [4:0] d;
    p = pos[4] ? 4'd0 : pos[3:0];
    d = {1'b0, fd} - {1'b0, p};
    return d[4] ? 4'd0 : d[3:0];
  endfunction

  function automatic count_t count_up(input count_t c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 4'd1;
  endfunction

  // configuration
  frac_t frac_r;
  word_t max_r;

  // entry state
  word_t  val_r, val_nxt;
  pos_t   pt_r, pt_nxt;
  count_t cnt_r, cnt_nxt;

  // work registers
  key_t         key_r, key_nxt;
  word_t        cand_r, cand_nxt;
  pos_t         np_r, np_nxt;
  logic [32:0]  w_r, w_nxt;
  count_t       sc_r, sc_nxt;
  logic [63:0]  prod_r, prod_nxt;
  logic         status_r, status_nxt;

  // result register
  logic   o_status_r;
  word_t  o_val_r, o_sc_r;
  pos_t   o_pt_r;
  count_t o_cnt_r;

  logic [35:0] nv;
  logic [32:0] nv_clamp;
  logic [36:0] w10;
  logic [32:0] w10_clamp;
  pos_t        np;

  // candidate value with the new digit, clamped at 2^32
  assign nv       = {1'b0, val_r, 3'b000} + {3'b000, val_r, 1'b0} + {32'd0, key_r};
  assign nv_clamp = (nv > {3'b000, LIM33}) ? LIM33 : nv[32:0];
  assign np       = (pt_r >= 0) ? pt_r + 5'sd1 : pt_r;

  // clamped multiply by ten
  assign w10       = {1'b0, w_r, 3'b000} + {3'b000, w_r, 1'b0};
  assign w10_clamp = (w10 > {4'b0000, LIM33}) ? LIM33 : w10[32:0];

  assign stat.digit_ok = (key_r <= KEY_DIGIT_MAX)
                       && (key_r != KEY_ZERO || val_r != '0 || pt_r >= 0)
                       && (pt_r < $signed({1'b0, frac_r}));
  assign stat.div_need = (key_r == KEY_BACK) && (pt_r != 5'sd0);
  assign stat.cnt_zero = (sc_r == 4'd0);

  always_comb begin
    val_nxt    = val_r;
    pt_nxt     = pt_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    cand_nxt   = cand_r;
    np_nxt     = np_r;
    w_nxt      = w_r;
    sc_nxt     = sc_r;
    prod_nxt   = prod_r;
    status_nxt = status_r;

    // new beat, start clears the entry first
    if (cmd.latch) begin
      key_nxt = in_key;
      if (in_action) begin
        val_nxt = '0;
        pt_nxt  = POS_NONE;
        cnt_nxt = '0;
      end
    end

    // key decode
    if (cmd.eval) begin
      status_nxt = STAT_OK;
      if (stat.digit_ok) begin
        cand_nxt = nv[31:0];
        w_nxt    = nv_clamp;
        sc_nxt   = scale_cnt(frac_r, np);
        np_nxt   = np;
      end else if (key_r == KEY_POINT) begin
        if (pt_r < 0) begin
          pt_nxt = 5'sd0;
          if (val_r == '0) cnt_nxt = count_up(cnt_r);
        end
      end else if (key_r == KEY_BACK) begin
        if (pt_r == 5'sd0) begin
          pt_nxt = POS_NONE;
          if (val_r == '0) cnt_nxt = '0;
        end else begin
          prod_nxt = {32'd0, val_r} * {32'd0, RECIP10};
        end
      end
    end

    // backspace removes a digit
    if (cmd.div_fin) begin
      val_nxt = {3'b000, prod_r[63:RECIP_SHIFT]};
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 4'd1;
        if (pt_r > 0) pt_nxt = pt_r - 5'sd1;
      end
    end

    if (cmd.mul_step) begin
      w_nxt  = w10_clamp;
      sc_nxt = sc_r - 4'd1;
    end

    // maximum check on the appended digit
    if (cmd.check) begin
      if (w_r > {1'b0, max_r}) begin
        status_nxt = STAT_AT_MAX;
      end else begin
        val_nxt = cand_r;
        pt_nxt  = np_r;
        cnt_nxt = count_up(cnt_r);
      end
    end

    if (cmd.scale_load) begin
      w_nxt  = {1'b0, val_r};
      sc_nxt = scale_cnt(frac_r, pt_r);
    end
  end

  // config and entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= '0;
      max_r  <= '1;
      val_r  <= '0;
      pt_r   <= POS_NONE;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAC) frac_r <= cfg_wdata[3:0];
        else                       max_r  <= cfg_wdata;
      end
      val_r <= val_nxt;
      pt_r  <= pt_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // work and result payload
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    cand_r   <= cand_nxt;
    np_r     <= np_nxt;
    w_r      <= w_nxt;
    sc_r     <= sc_nxt;
    prod_r   <= prod_nxt;
    status_r <= status_nxt;
    if (cmd.out_load) begin
      o_status_r <= status_r;
      o_val_r    <= val_r;
      o_pt_r     <= pt_r;
      o_cnt_r    <= cnt_r;
      o_sc_r     <= w_r[32] ? '1 : w_r[31:0];
    end
  end

  assign out_status         = o_status_r;
  assign out_digits_value   = o_val_r;
  assign out_point_position = o_pt_r;
  assign out_digit_count    = o_cnt_r;
  assign out_scaled_value   = o_sc_r;

endmodule

/* rtl/decimal_keypad_entry_editor.sv */
// Keypad decimal-number entry editor.
// in_bus (valid/ready): one beat per key press, action (1 = start, clear the
// entry first) and key (0-9 digit, 10 point, 11 backspace, others ignored).
// out_bus (valid/ready): one result beat per input beat: status (1 = digit
// refused at max), the typed integer, point position (-1 none), digit count
// and the entry scaled by ten to the configured fraction digits.
// cfg_we/cfg_index/cfg_wdata: index 0 fraction digits, index 1 max value;
// write only while no beat is in flight.
// Per input beat the sequencer latches and decodes the key; a backspace
// that does not remove the point then runs the divide step, and a digit
// sent to the max check (kept or refused) runs a multiply-by-ten steps and
// the check. The entry is then scaled by b multiply-by-ten steps and the
// result loaded. a and b are each up to the fraction digit setting; both
// use one shared multiply-by-ten unit doing one step per cycle.
// One item is in work at a time; the next beat is taken the cycle after
// the result is loaded, even while that result is still waiting.
// Reset clears the entry (value 0, no point, count 0), fraction digits to 0
// and max to all ones. A stalled receiver holds the result register; the
// next finished result waits in the sequencer until the register frees.
module decimal_keypad_entry_editor (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  kpe_pkg::word_t cfg_wdata,
  kpe_in_if.sink         in_bus,
  kpe_out_if.source      out_bus
);
  import kpe_pkg::*;

  kpe_cmd_t  cmd;
  kpe_stat_t stat;

  kpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kpe_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_bus.action),
    .in_key             (in_bus.key),
    .cmd                (cmd),
    .stat               (stat),
    .out_status         (out_bus.status),
    .out_digits_value   (out_bus.digits_value),
    .out_point_position (out_bus.point_position),
    .out_digit_count    (out_bus.digit_count),
    .out_scaled_value   (out_bus.scaled_value)
  );

endmodule

/* tb/decimal_keypad_entry_editor_test.sv */
module decimal_keypad_entry_editor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kpe_pkg::*;

  localparam longint unsigned WORD_CAP = 64'h1_0000_0000;
  localparam int unsigned RADIX = 10;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASE_COUNT = 11;

  typedef struct {
    logic   status;
    word_t  digits;
    pos_t   point;
    count_t count;
    word_t  scaled;
  } entry_result_t;

  // Shadow of the entry editor plus the queue of results still owed.
  class entry_scoreboard;
    frac_t frac_digits;
    word_t max_scaled;
    word_t typed;
    int point_at;
    int typed_digits;
    entry_result_t owed[$];
    int errors;

    function new();
      frac_digits = '0;
      max_scaled = '1;
      typed = '0;
      point_at = -1;
      typed_digits = 0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, word_t data);
      if (idx == CFG_FRAC) frac_digits = data[3:0];
      else max_scaled = data;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // times ten per missing fraction digit, held at 2^32 so nothing wraps
    function longint unsigned scale_clamped(longint unsigned v, int p);
      int e;
      longint unsigned r;
      e = int'(frac_digits);
      if (p > 0) e -= p;
      r = (v > WORD_CAP) ? WORD_CAP : v;
      while (e > 0) begin
        r = r * RADIX;
        if (r > WORD_CAP) r = WORD_CAP;
        e--;
      end
      return r;
    endfunction

    function void bump_count();
      if (typed_digits < int'(COUNT_MAX)) typed_digits++;
    endfunction

    // apply one accepted key beat and queue the result it owes
    function void note_key(logic start, key_t k);
      logic st;
      longint unsigned nv;
      longint unsigned sc;
      int np;
      entry_result_t r;
      st = STAT_OK;
      if (start) begin
        typed = '0;
        point_at = -1;
        typed_digits = 0;
      end
      if (k <= KEY_DIGIT_MAX) begin
        // leading zeros are dropped; full fraction ignores the digit
        if ((k != KEY_ZERO || typed != 0 || point_at >= 0) &&
            point_at < int'(frac_digits)) begin
          nv = longint'(typed) * RADIX + k;
          np = (point_at >= 0) ? point_at + 1 : point_at;
          if (scale_clamped(nv, np) > longint'(max_scaled)) begin
            st = STAT_AT_MAX;
          end else begin
            typed = nv[31:0];
            point_at = np;
            bump_count();
          end
        end
      end else if (k == KEY_POINT) begin
        if (point_at < 0) begin
          point_at = 0;
          if (typed == 0) bump_count();
        end
      end else if (k == KEY_BACK) begin
        if (point_at == 0) begin
          point_at = -1;
          if (typed == 0) typed_digits = 0;
        end else begin
          typed = typed / RADIX;
          if (typed_digits != 0) begin
            typed_digits--;
            if (point_at > 0) point_at--;
          end
        end
      end
      sc = scale_clamped(longint'(typed), point_at);
      if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
      r.status = st;
      r.digits = typed;
      r.point = pos_t'(point_at);
      r.count = count_t'(typed_digits);
      r.scaled = sc[31:0];
      owed.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(entry_result_t got);
      entry_result_t want;
      if (owed.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0b, want %0b", got.status, want.status));
      if (got.digits !== want.digits)
        report($sformatf("digits_value %0d, want %0d", got.digits, want.digits));
      if (got.point !== want.point)
        report($sformatf("point_position %0d, want %0d", got.point, want.point));
      if (got.count !== want.count)
        report($sformatf("digit_count %0d, want %0d", got.count, want.count));
      if (got.scaled !== want.scaled)
        report($sformatf("scaled_value %0d, want %0d", got.scaled, want.scaled));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  word_t cfg_wdata;

  kpe_in_if in_bus ();
  kpe_out_if out_bus ();

  decimal_keypad_entry_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  entry_scoreboard sb = new();
  int send_idle = 18;
  int rcv_idle = 50;
  int keys_sent = 0;
  int quiet_cycles = 0;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_bus.ready <= rst_n && ($urandom_range(99) >= rcv_idle);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    entry_result_t got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_key(in_bus.action, in_bus.key);
      if (out_bus.valid && out_bus.ready) begin
        got.status = out_bus.status;
        got.digits = out_bus.digits_value;
        got.point = out_bus.point_position;
        got.count = out_bus.digit_count;
        got.scaled = out_bus.scaled_value;
        sb.check_result(got);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("decimal_keypad_entry_editor_test: errors");
        $finish;
      end
    end
  end

  // Tasks below start and end just after a falling edge.
  task send_key(logic start, key_t k);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.action = start;
    in_bus.key = k;
    do @(posedge clk); while (!in_bus.ready);
    keys_sent++;
    @(negedge clk);
  endtask

  // hold off input until every result is back and the block has settled
  task drain();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_reg(logic idx, word_t data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 62) return key_t'($urandom_range(9));
    if (r < 74) return KEY_POINT;
    if (r < 90) return KEY_BACK;
    return key_t'($urandom_range(15, 12));
  endfunction

  // one entry: a start, then a run of keys with the odd stray start
  task send_entry();
    int len;
    len = $urandom_range(14, 2);
    send_key(1'b1, pick_key());
    repeat (len) send_key($urandom_range(29) == 0, pick_key());
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAC;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = 1'b0;
    in_bus.key = KEY_ZERO;
    out_bus.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, no fraction digits, max all ones
    send_key(1'b1, KEY_ZERO);          // suppressed zero
    send_key(1'b0, key_t'(12));        // ignored key
    send_key(1'b0, key_t'(15));
    send_key(1'b0, KEY_BACK);          // backspace on empty
    send_key(1'b1, key_t'(4));
    send_key(1'b0, key_t'(2));
    send_key(1'b0, key_t'(9));
    send_key(1'b0, key_t'(4));
    send_key(1'b0, key_t'(9));
    send_key(1'b0, key_t'(6));
    send_key(1'b0, key_t'(7));
    send_key(1'b0, key_t'(2));
    send_key(1'b0, key_t'(9));
    send_key(1'b0, key_t'(5));         // 4294967295, right at max
    send_key(1'b0, key_t'(9));         // beyond 32 bits, refused
    send_key(1'b0, KEY_POINT);
    send_key(1'b0, key_t'(3));         // fraction already full
    send_key(1'b0, KEY_POINT);         // second point
    send_key(1'b0, KEY_BACK);          // drops the point

    // raising the scale on a big entry saturates the output
    drain();
    write_reg(CFG_FRAC, 32'd9);
    send_key(1'b0, key_t'(14));
    send_key(1'b1, KEY_POINT);
    send_key(1'b0, KEY_ZERO);
    send_key(1'b0, KEY_ZERO);
    send_key(1'b0, key_t'(7));

    // point now beyond the fraction setting, then a low maximum
    drain();
    write_reg(CFG_FRAC, 32'd1);
    write_reg(CFG_MAX, 32'd12345);
    send_key(1'b0, KEY_BACK);
    send_key(1'b1, key_t'(1));
    send_key(1'b0, key_t'(2));
    send_key(1'b0, key_t'(3));
    send_key(1'b0, key_t'(4));
    send_key(1'b0, key_t'(5));         // refused at max

    // random phases across settings and idle patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      if (p < 4) begin
        send_idle = 18;
        rcv_idle = 50;
      end else if (p < 8) begin
        send_idle = 50;
        rcv_idle = 18;
      end else begin
        send_idle = 0;
        rcv_idle = 0;
      end
      case (p)
        0: begin write_reg(CFG_FRAC, 32'd0); write_reg(CFG_MAX, '1); end
        1: begin write_reg(CFG_FRAC, 32'd9); write_reg(CFG_MAX, '1); end
        2: begin write_reg(CFG_FRAC, 32'd2); write_reg(CFG_MAX, 32'd99999); end
        3: begin write_reg(CFG_FRAC, 32'd9); write_reg(CFG_MAX, 32'd0); end
        4: write_reg(CFG_FRAC, 32'd0);
        5: write_reg(CFG_MAX, 32'd1000);
        default: begin
          write_reg(CFG_FRAC, word_t'($urandom_range(9)));
          write_reg(CFG_MAX, $urandom() >> $urandom_range(31));
        end
      endcase
      target = keys_sent + PHASE_ITEMS;
      while (keys_sent < target) send_entry();
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("decimal_keypad_entry_editor_test: clean");
    end else begin
      $display("decimal_keypad_entry_editor_test: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kpe_pkg.sv
rtl/kpe_in_if.sv
rtl/kpe_out_if.sv
rtl/kpe_ctrl.sv
rtl/kpe_dp.sv
rtl/decimal_keypad_entry_editor.sv
tb/decimal_keypad_entry_editor_test.sv
